[hw/rtl/les_pkg.sv]
// Shared types and constants for the LOOK elevator scheduler.
`timescale 1ns / 1ps

package les_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned SectorBitsDefault = 48;
  localparam int unsigned LengthBits        = 16;
  localparam int unsigned PendingBits       = 5;

  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_DISPATCH = 1'b1
  } les_op_t;

  typedef enum logic [1:0] {
    RES_ADDED      = 2'd0,
    RES_FULL       = 2'd1,
    RES_DISPATCHED = 2'd2,
    RES_EMPTY      = 2'd3
  } les_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_PICK
  } les_state_t;

  // Command handed from the front queue to the scheduler core.
  typedef struct packed {
    logic    valid;
    les_op_t op;
  } les_cmd_t;

  // Result control handed from the scheduler core to the result queue.
  typedef struct packed {
    logic        push;
    les_status_t status;
    logic        moving_up;
  } les_res_ctl_t;

endpackage

[hw/rtl/les_front.sv]
// Front queue: take input items, decode the opcode and hold them for the core.
`timescale 1ns / 1ps

module les_front #(
  parameter int unsigned SECTOR_BITS = les_pkg::SectorBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_opcode,
  input  logic [SECTOR_BITS-1:0]        in_request_sector,
  input  logic [les_pkg::LengthBits-1:0] in_request_length,
  output les_pkg::les_cmd_t             cmd,
  input  logic                          cmd_ready,
  output logic [SECTOR_BITS-1:0]        cmd_sector,
  output logic [les_pkg::LengthBits-1:0] cmd_length
);
  import les_pkg::*;

  les_op_t               op_r     [2];
  logic [SECTOR_BITS-1:0] sec_r   [2];
  logic [LengthBits-1:0] len_r    [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            count_r, count_nxt;
  logic                  wr_en;
  logic                  rd_en;
  les_op_t               op_dec;

  always_comb begin
    op_dec = les_op_t'(in_opcode);
  end

  assign in_full   = (count_r == 2'd2);
  assign wr_en     = in_push && !in_full;
  assign cmd.valid = (count_r != 2'd0);
  assign cmd.op    = op_r[rd_ptr_r];
  assign cmd_sector = sec_r[rd_ptr_r];
  assign cmd_length = len_r[rd_ptr_r];
  assign rd_en     = cmd.valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    count_nxt  = count_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      op_r[wr_ptr_r]  <= op_dec;
      sec_r[wr_ptr_r] <= in_request_sector;
      len_r[wr_ptr_r] <= in_request_length;
    end
  end

endmodule

[hw/rtl/les_core.sv]
// Scheduler core: request table, serial LOOK search and head/direction state.
`timescale 1ns / 1ps

module les_core #(
  parameter int unsigned TABLE_DEPTH = les_pkg::TableDepthDefault,
  parameter int unsigned SECTOR_BITS = les_pkg::SectorBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  les_pkg::les_cmd_t               cmd,
  output logic                            cmd_ready,
  input  logic [SECTOR_BITS-1:0]          cmd_sector,
  input  logic [les_pkg::LengthBits-1:0]  cmd_length,
  input  logic                            res_full,
  output les_pkg::les_res_ctl_t           res_ctl,
  output logic [SECTOR_BITS-1:0]          res_sector,
  output logic [les_pkg::LengthBits-1:0]  res_length,
  output logic [les_pkg::PendingBits-1:0] res_pending
);
  import les_pkg::*;

  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned HeadW = SECTOR_BITS + 1;

  logic [SECTOR_BITS-1:0] sec_r [TABLE_DEPTH];
  logic [LengthBits-1:0]  len_r [TABLE_DEPTH];

  les_state_t             state_r, state_nxt;
  logic [CntW-1:0]        held_r, held_nxt;
  logic [HeadW-1:0]       head_r, head_nxt;
  logic                   up_r, up_nxt;
  logic [IdxW-1:0]        idx_r, idx_nxt;

  logic                   rd_vld_r;
  logic [SECTOR_BITS-1:0] rd_sec_r;
  logic [LengthBits-1:0]  rd_len_r;
  logic [IdxW-1:0]        rd_idx_r;

  logic                   have_up_r, have_dn_r;
  logic [IdxW-1:0]        up_idx_r, dn_idx_r;
  logic [SECTOR_BITS-1:0] up_sec_r, dn_sec_r;
  logic [LengthBits-1:0]  up_len_r, dn_len_r;

  logic                   tbl_add;
  logic                   tbl_remove;
  logic                   scan_start;
  logic                   scan_read;
  logic                   last_idx;
  logic                   table_full;
  logic                   table_empty;
  logic                   pick_up;
  logic [IdxW-1:0]        pick_idx;
  logic [SECTOR_BITS-1:0] pick_sec;
  logic [LengthBits-1:0]  pick_len;
  logic [HeadW-1:0]       rd_ext;
  logic                   take_up;
  logic                   take_dn;

  assign table_full  = (held_r == CntW'(TABLE_DEPTH));
  assign table_empty = (held_r == '0);
  assign last_idx    = ((CntW'(idx_r) + CntW'(1)) == held_r);

  // LOOK turn: reverse when nothing lies ahead, then reverse back if that side is empty too.
  always_comb begin
    pick_up = up_r;
    if (pick_up && !have_up_r) begin
      pick_up = 1'b0;
    end
    if (!pick_up && !have_dn_r) begin
      pick_up = 1'b1;
    end
    pick_idx = pick_up ? up_idx_r : dn_idx_r;
    pick_sec = pick_up ? up_sec_r : dn_sec_r;
    pick_len = pick_up ? up_len_r : dn_len_r;
  end

  // Strict compares keep the oldest request among equal sectors.
  assign rd_ext  = {1'b0, rd_sec_r};
  assign take_up = rd_vld_r && (rd_ext >= head_r) && (!have_up_r || (rd_sec_r < up_sec_r));
  assign take_dn = rd_vld_r && (rd_ext <= head_r) && (!have_dn_r || (rd_sec_r > dn_sec_r));

  always_comb begin
    state_nxt   = state_r;
    held_nxt    = held_r;
    head_nxt    = head_r;
    up_nxt      = up_r;
    idx_nxt     = idx_r;
    cmd_ready   = 1'b0;
    tbl_add     = 1'b0;
    tbl_remove  = 1'b0;
    scan_start  = 1'b0;
    scan_read   = 1'b0;
    res_ctl     = '{push: 1'b0, status: RES_ADDED, moving_up: up_r};
    res_sector  = '0;
    res_length  = '0;
    res_pending = PendingBits'(held_r);

    case (state_r)
      B_IDLE: begin
        cmd_ready = !res_full;
        if (cmd.valid && !res_full) begin
          if (cmd.op == OP_ADD) begin
            res_ctl.push = 1'b1;
            if (table_full) begin
              res_ctl.status = RES_FULL;
            end else begin
              tbl_add        = 1'b1;
              held_nxt       = held_r + CntW'(1);
              res_ctl.status = RES_ADDED;
              res_pending    = PendingBits'(held_nxt);
            end
          end else if (table_empty) begin
            res_ctl.push   = 1'b1;
            res_ctl.status = RES_EMPTY;
          end else begin
            scan_start = 1'b1;
            idx_nxt    = '0;
            state_nxt  = B_SCAN;
          end
        end
      end
      B_SCAN: begin
        scan_read = 1'b1;
        if (last_idx) begin
          state_nxt = B_DRAIN;
        end else begin
          idx_nxt = idx_r + IdxW'(1);
        end
      end
      B_DRAIN: begin
        state_nxt = B_PICK;
      end
      B_PICK: begin
        tbl_remove        = 1'b1;
        held_nxt          = held_r - CntW'(1);
        up_nxt            = pick_up;
        head_nxt          = {1'b0, pick_sec} + HeadW'(pick_len);
        res_ctl.push      = 1'b1;
        res_ctl.status    = RES_DISPATCHED;
        res_ctl.moving_up = pick_up;
        res_sector        = pick_sec;
        res_length        = pick_len;
        res_pending       = PendingBits'(held_nxt);
        state_nxt         = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      held_r    <= '0;
      head_r    <= '0;
      up_r      <= 1'b1;
      idx_r     <= '0;
      rd_vld_r  <= 1'b0;
      have_up_r <= 1'b0;
      have_dn_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      head_r   <= head_nxt;
      up_r     <= up_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= scan_read;
      if (scan_start) begin
        have_up_r <= 1'b0;
        have_dn_r <= 1'b0;
      end else begin
        if (take_up) begin
          have_up_r <= 1'b1;
        end
        if (take_dn) begin
          have_dn_r <= 1'b1;
        end
      end
    end
  end

  // Search datapath: register one entry per cycle, then fold it into the best candidates.
  always_ff @(posedge clk) begin
    if (scan_read) begin
      rd_sec_r <= sec_r[idx_r];
      rd_len_r <= len_r[idx_r];
      rd_idx_r <= idx_r;
    end
    if (take_up) begin
      up_idx_r <= rd_idx_r;
      up_sec_r <= rd_sec_r;
      up_len_r <= rd_len_r;
    end
    if (take_dn) begin
      dn_idx_r <= rd_idx_r;
      dn_sec_r <= rd_sec_r;
      dn_len_r <= rd_len_r;
    end
  end

  // Table stays packed in arrival order: append at the tail, close the gap on removal.
  always_ff @(posedge clk) begin
    if (tbl_add) begin
      sec_r[held_r[IdxW-1:0]] <= cmd_sector;
      len_r[held_r[IdxW-1:0]] <= cmd_length;
    end
    if (tbl_remove) begin
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
        if (IdxW'(i) >= pick_idx) begin
          sec_r[i] <= sec_r[i+1];
          len_r[i] <= len_r[i+1];
        end
      end
    end
  end

endmodule

[hw/rtl/les_resq.sv]
// Result queue: two-entry buffer between the core and the result port.
`timescale 1ns / 1ps

module les_resq #(
  parameter int unsigned SECTOR_BITS = les_pkg::SectorBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  les_pkg::les_res_ctl_t           res_ctl,
  input  logic [SECTOR_BITS-1:0]          res_sector,
  input  logic [les_pkg::LengthBits-1:0]  res_length,
  input  logic [les_pkg::PendingBits-1:0] res_pending,
  output logic                            res_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [1:0]                      out_status,
  output logic [SECTOR_BITS-1:0]          out_dispatched_sector,
  output logic [les_pkg::LengthBits-1:0]  out_dispatched_length,
  output logic                            out_moving_up,
  output logic [les_pkg::PendingBits-1:0] out_pending_count
);
  import les_pkg::*;

  les_status_t            st_r  [2];
  logic                   up_r  [2];
  logic [SECTOR_BITS-1:0] sec_r [2];
  logic [LengthBits-1:0]  len_r [2];
  logic [PendingBits-1:0] pnd_r [2];
  logic                   wr_ptr_r, wr_ptr_nxt;
  logic                   rd_ptr_r, rd_ptr_nxt;
  logic [1:0]             count_r, count_nxt;
  logic                   wr_en;
  logic                   rd_en;

  assign res_full  = (count_r == 2'd2);
  assign out_empty = (count_r == 2'd0);
  assign wr_en     = res_ctl.push && !res_full;
  assign rd_en     = out_pop && !out_empty;

  assign out_status            = 2'(st_r[rd_ptr_r]);
  assign out_moving_up         = up_r[rd_ptr_r];
  assign out_dispatched_sector = sec_r[rd_ptr_r];
  assign out_dispatched_length = len_r[rd_ptr_r];
  assign out_pending_count     = pnd_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    count_nxt  = count_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      st_r[wr_ptr_r]  <= res_ctl.status;
      up_r[wr_ptr_r]  <= res_ctl.moving_up;
      sec_r[wr_ptr_r] <= res_sector;
      len_r[wr_ptr_r] <= res_length;
      pnd_r[wr_ptr_r] <= res_pending;
    end
  end

endmodule

[hw/rtl/look_elevator_scheduler.sv]
// Top level of the LOOK disk request scheduler.
`timescale 1ns / 1ps
// Usage:
//   Input side is a queue: drive in_opcode / in_request_sector / in_request_length
//   and raise in_push; the item transfers on a clock edge where in_full is low.
//   Opcode add stores a request; opcode dispatch removes the next request in
//   LOOK order (nearest sector ahead of the head, turning when nothing is ahead,
//   oldest first among equal sectors) and moves the head to sector plus length.
//   Result side is a queue too: while out_empty is low the oldest result is on
//   the out_ ports, and it transfers on an edge where out_pop is high.
//   Every item gives exactly one result, in order.
// Timing:
//   An add, and a dispatch on an empty table, is answered in the idle state and its
//   result is registered in the result queue. A dispatch scans the table one entry
//   per cycle through a registered compare stage, then passes the drain and pick
//   states; the serial scan sets the rate. Two-entry queues on both sides keep
//   taking input while a result waits. When the receiver stalls, the result queue
//   fills, the core holds, then the input queue fills and in_full rises; nothing is dropped.
// Reset:
//   rst_n low at a clock edge empties both queues and the table, puts the head
//   at sector zero and sets the direction to upward.

module look_elevator_scheduler #(
  parameter int unsigned TABLE_DEPTH = les_pkg::TableDepthDefault,
  parameter int unsigned SECTOR_BITS = les_pkg::SectorBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_opcode,
  input  logic [SECTOR_BITS-1:0]          in_request_sector,
  input  logic [les_pkg::LengthBits-1:0]  in_request_length,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [1:0]                      out_status,
  output logic [SECTOR_BITS-1:0]          out_dispatched_sector,
  output logic [les_pkg::LengthBits-1:0]  out_dispatched_length,
  output logic                            out_moving_up,
  output logic [les_pkg::PendingBits-1:0] out_pending_count
);
  import les_pkg::*;

  // Front to core
  les_cmd_t               cmd;
  logic                   cmd_ready;
  logic [SECTOR_BITS-1:0] cmd_sector;
  logic [LengthBits-1:0]  cmd_length;

  // Core to result queue
  les_res_ctl_t           res_ctl;
  logic                   res_full;
  logic [SECTOR_BITS-1:0] res_sector;
  logic [LengthBits-1:0]  res_length;
  logic [PendingBits-1:0] res_pending;

  // Accept and decode input items; hold them until the core is free.
  les_front #(
    .SECTOR_BITS (SECTOR_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_opcode         (in_opcode),
    .in_request_sector (in_request_sector),
    .in_request_length (in_request_length),
    .cmd               (cmd),
    .cmd_ready         (cmd_ready),
    .cmd_sector        (cmd_sector),
    .cmd_length        (cmd_length)
  );

  // Execute one item at a time against the request table.
  les_core #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cmd_ready   (cmd_ready),
    .cmd_sector  (cmd_sector),
    .cmd_length  (cmd_length),
    .res_full    (res_full),
    .res_ctl     (res_ctl),
    .res_sector  (res_sector),
    .res_length  (res_length),
    .res_pending (res_pending)
  );

  // Buffer finished results so the core keeps going while the receiver stalls.
  les_resq #(
    .SECTOR_BITS (SECTOR_BITS)
  ) u_resq (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .res_ctl               (res_ctl),
    .res_sector            (res_sector),
    .res_length            (res_length),
    .res_pending           (res_pending),
    .res_full              (res_full),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_status            (out_status),
    .out_dispatched_sector (out_dispatched_sector),
    .out_dispatched_length (out_dispatched_length),
    .out_moving_up         (out_moving_up),
    .out_pending_count     (out_pending_count)
  );

  // The core only produces a result when the result queue has room for it.
  a_no_result_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    res_ctl.push |-> !res_full)
    else $error("core pushed a result into a full result queue");

  // Only a dispatched result carries a sector and a length.
  a_idle_payload_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status != 2'(RES_DISPATCHED))) |->
      ((out_dispatched_sector == '0) && (out_dispatched_length == '0)))
    else $error("non-dispatch result carries a payload");

  // A rejected add reports a full table.
  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status == 2'(RES_FULL))) |->
      (out_pending_count == PendingBits'(TABLE_DEPTH)))
    else $error("table-full result with wrong pending count");

  // A command transfers to the core only while the core is idle and has room to answer.
  a_cmd_handoff : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.valid && cmd_ready) |-> !res_full)
    else $error("command taken while result queue is full");

endmodule
